### hdl/assert_macros.svh
// Assertion macros used by the port checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is asserted
`define CSP_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("csp check failed");

// payload holds while a beat waits
`define CSP_ASSERT_HOLD(label, v, r, d) \
	`CSP_ASSERT(label, v && !r |=> $stable(d))

`endif

### hdl/csp_pkg.sv
// Package: types, constants and fixed-point helpers of the spline evaluator
`timescale 1ns / 1ps
package csp_pkg;

	localparam int MAX_KNOTS   = 64;
	localparam int IDX_W       = $clog2(MAX_KNOTS);
	localparam int CNT_W       = 7;
	localparam int VALUE_WIDTH = 32;
	localparam int FRAC        = 24;
	localparam int FIFO_DEPTH  = 4;
	localparam int PTR_W       = $clog2(FIFO_DEPTH);

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic signed [63:0] Q_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] Q_MIN = 64'sh8000_0000_0000_0000;
	localparam logic signed [63:0] Q_ONE = 64'sh0000_0000_0100_0000;

	// high product bits shifted right by two give the quotient by six
	localparam logic [63:0] RECIP6 = 64'hAAAA_AAAA_AAAA_AAAB;

	typedef struct packed {
		logic              operation;
		logic [5:0]        knot_index;
		logic signed [31:0] knot_abscissa;
		logic signed [31:0] knot_ordinate;
		logic signed [31:0] knot_second_derivative;
		logic signed [31:0] query_x;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic signed [31:0] slope;
		logic signed [31:0] curvature;
		logic              bad_knots;
	} out_item_t;

	typedef struct packed {
		logic              is_query;
		logic [5:0]        index;
		logic signed [31:0] xa;
		logic signed [31:0] y;
		logic signed [31:0] s;
	} entry_t;

	typedef struct packed {
		logic              start;
		logic              raw;
		logic signed [63:0] x;
		logic signed [63:0] y;
	} mul_req_t;

	typedef struct packed {
		logic              done;
		logic signed [63:0] res;
	} mul_rsp_t;

	typedef struct packed {
		logic        start;
		logic [63:0] num;
		logic [33:0] den;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] quo;
	} div_rsp_t;

	function automatic logic [63:0] mag(input logic signed [63:0] x);
		logic [63:0] r;
		r = x[63] ? (64'd0 - 64'(x)) : 64'(x);
		return r;
	endfunction

	function automatic logic signed [63:0] from_mag(input logic [63:0] m, input logic neg);
		logic signed [63:0] r;
		if (neg) begin
			r = m[63] ? Q_MIN : -$signed(m);
		end else begin
			r = m[63] ? Q_MAX : $signed(m);
		end
		return r;
	endfunction

	function automatic logic signed [63:0] add_sat(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [63:0] s;
		s = a + b;
		if (a[63] == b[63] && s[63] != a[63]) begin
			s = a[63] ? Q_MIN : Q_MAX;
		end
		return s;
	endfunction

	function automatic logic signed [63:0] sub_sat(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [63:0] d;
		d = a - b;
		if (a[63] != b[63] && d[63] != a[63]) begin
			d = a[63] ? Q_MIN : Q_MAX;
		end
		return d;
	endfunction

	function automatic logic [31:0] to_out(input logic signed [63:0] x);
		logic [63:0]        m;
		logic signed [63:0] v;
		logic signed [63:0] lim;
		m   = mag(x) + 64'd128;
		v   = from_mag(m >> 8, x[63]);
		lim = (64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1;
		if (v > lim) begin
			v = lim;
		end
		if (v < -lim - 64'sd1) begin
			v = -lim - 64'sd1;
		end
		return v[31:0];
	endfunction

endpackage

### hdl/csp_front.sv
// Front: accepts input beats, classifies them and feeds the queue
`timescale 1ns / 1ps
module csp_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  csp_pkg::in_item_t in_data,
	output logic              push,
	output csp_pkg::entry_t   push_data,
	input  logic              full
);

	logic            valid_s1;
	csp_pkg::entry_t entry_s1;

	assign in_ready  = !valid_s1 || !full;
	assign push      = valid_s1 && !full;
	assign push_data = entry_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			entry_s1.is_query <= (in_data.operation == csp_pkg::OP_QUERY);
			entry_s1.index    <= in_data.knot_index;
			entry_s1.xa       <= (in_data.operation == csp_pkg::OP_QUERY) ?
				in_data.query_x : in_data.knot_abscissa;
			entry_s1.y        <= in_data.knot_ordinate;
			entry_s1.s        <= in_data.knot_second_derivative;
		end
	end

endmodule

### hdl/csp_fifo.sv
// Short queue between the front and the engine
`timescale 1ns / 1ps
module csp_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  csp_pkg::entry_t push_data,
	output logic            full,
	input  logic            pop,
	output logic            empty,
	output csp_pkg::entry_t pop_data
);

	csp_pkg::entry_t               slots_q [csp_pkg::FIFO_DEPTH];
	logic [csp_pkg::PTR_W-1:0]     wptr_q;
	logic [csp_pkg::PTR_W-1:0]     rptr_q;
	logic [csp_pkg::PTR_W:0]       fill_q;

	assign full     = (fill_q == (csp_pkg::PTR_W + 1)'(csp_pkg::FIFO_DEPTH));
	assign empty    = (fill_q == '0);
	assign pop_data = slots_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wptr_q] <= push_data;
		end
	end

endmodule

### hdl/csp_mul.sv
// Q.24 multiplier: four 32x32 partial products, rounded and saturated, or raw high part
`timescale 1ns / 1ps
module csp_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  csp_pkg::mul_req_t req,
	output csp_pkg::mul_rsp_t rsp
);

	logic               busy_q;
	logic               done_q;
	logic [2:0]         cnt_q;
	logic [63:0]        xm_q;
	logic [63:0]        ym_q;
	logic               neg_q;
	logic               raw_q;
	logic [63:0]        pp_q;
	logic [127:0]       acc_q;
	logic signed [63:0] res_q;

	logic [31:0]  xa;
	logic [31:0]  ya;
	logic [63:0]  prod;
	logic [127:0] shifted;
	logic [127:0] rnd;
	logic signed [63:0] fin;

	assign xa   = cnt_q[1] ? xm_q[63:32] : xm_q[31:0];
	assign ya   = cnt_q[0] ? ym_q[63:32] : ym_q[31:0];
	assign prod = xa * ya;

	always_comb begin
		case (cnt_q)
			3'd1:    shifted = {64'd0, pp_q};
			3'd2:    shifted = {32'd0, pp_q, 32'd0};
			3'd3:    shifted = {32'd0, pp_q, 32'd0};
			3'd4:    shifted = {pp_q, 64'd0};
			default: shifted = '0;
		endcase
	end

	assign rnd = acc_q + (128'd1 << (csp_pkg::FRAC - 1));
	assign fin = (|rnd[127:64 + csp_pkg::FRAC]) ?
		(neg_q ? csp_pkg::Q_MIN : csp_pkg::Q_MAX) :
		csp_pkg::from_mag(rnd[63 + csp_pkg::FRAC:csp_pkg::FRAC], neg_q);

	assign rsp.done = done_q;
	assign rsp.res  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 3'd5) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			xm_q  <= req.raw ? 64'(req.x) : csp_pkg::mag(req.x);
			ym_q  <= req.raw ? 64'(req.y) : csp_pkg::mag(req.y);
			neg_q <= !req.raw && (req.x[63] ^ req.y[63]);
			raw_q <= req.raw;
			acc_q <= '0;
		end else if (busy_q) begin
			if (cnt_q < 3'd4) begin
				pp_q <= prod;
			end
			acc_q <= acc_q + shifted;
			if (cnt_q == 3'd5) begin
				res_q <= raw_q ? $signed({2'b00, acc_q[127:66]}) : fin;
			end
		end
	end

endmodule

### hdl/csp_div.sv
// Restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module csp_div (
	input  logic              clk,
	input  logic              arst_n,
	input  csp_pkg::div_req_t req,
	output csp_pkg::div_rsp_t rsp
);

	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [33:0] rem_q;
	logic [33:0] den_q;
	logic [63:0] quo_q;

	logic [34:0] trial;
	logic [34:0] diff;
	logic        ge;

	assign trial = {rem_q, quo_q[63]};
	assign ge    = (trial >= {1'b0, den_q});
	assign diff  = trial - {1'b0, den_q};

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			den_q <= req.den;
			quo_q <= req.num;
		end else if (busy_q) begin
			rem_q <= ge ? diff[33:0] : trial[33:0];
			quo_q <= {quo_q[62:0], ge};
		end
	end

endmodule

### hdl/csp_engine.sv
// Engine: knot store, interval search and evaluation sequencer
`timescale 1ns / 1ps
module csp_engine (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [csp_pkg::CNT_W-1:0]   knot_count,
	input  logic                        empty,
	input  csp_pkg::entry_t             pop_data,
	output logic                        pop,
	output logic                        out_valid,
	input  logic                        out_ready,
	output csp_pkg::out_item_t          out_data
);

	localparam int IW = csp_pkg::IDX_W;

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_SRCH_RD  = 4'd1;
	localparam logic [3:0] S_SRCH_CMP = 4'd2;
	localparam logic [3:0] S_LD_LO    = 4'd3;
	localparam logic [3:0] S_LD_HI    = 4'd4;
	localparam logic [3:0] S_LD_END   = 4'd5;
	localparam logic [3:0] S_ISSUE    = 4'd6;
	localparam logic [3:0] S_WAIT     = 4'd7;
	localparam logic [3:0] S_STORE    = 4'd8;

	localparam logic [4:0] P_A     = 5'd0;
	localparam logic [4:0] P_B     = 5'd1;
	localparam logic [4:0] P_Q     = 5'd2;
	localparam logic [4:0] P_AA    = 5'd3;
	localparam logic [4:0] P_AAA   = 5'd4;
	localparam logic [4:0] P_BB    = 5'd5;
	localparam logic [4:0] P_BBB   = 5'd6;
	localparam logic [4:0] P_TSLO  = 5'd7;
	localparam logic [4:0] P_TSHI  = 5'd8;
	localparam logic [4:0] P_HH    = 5'd9;
	localparam logic [4:0] P_THH   = 5'd10;
	localparam logic [4:0] P_DIV6Y = 5'd11;
	localparam logic [4:0] P_AY    = 5'd12;
	localparam logic [4:0] P_BY    = 5'd13;
	localparam logic [4:0] P_DSLO  = 5'd14;
	localparam logic [4:0] P_DSHI  = 5'd15;
	localparam logic [4:0] P_TH    = 5'd16;
	localparam logic [4:0] P_DIV6D = 5'd17;
	localparam logic [4:0] P_CSLO  = 5'd18;
	localparam logic [4:0] P_CSHI  = 5'd19;

	logic [31:0] mem_x [csp_pkg::MAX_KNOTS];
	logic [31:0] mem_y [csp_pkg::MAX_KNOTS];
	logic [31:0] mem_s [csp_pkg::MAX_KNOTS];
	logic [31:0] rd_x;
	logic [31:0] rd_y;
	logic [31:0] rd_s;
	logic [IW-1:0] rd_addr;
	logic          wr_en;
	logic [IW-1:0] wr_addr;

	logic [3:0]    state_q;
	logic [4:0]    step_q;
	logic [IW-1:0] lo_q;
	logic [IW-1:0] hi_q;
	logic          bad_q;
	logic          res_valid_q;
	csp_pkg::out_item_t res_q;

	logic signed [31:0] x_q;
	logic signed [31:0] xlo_q;
	logic signed [31:0] ylo_q;
	logic signed [31:0] slo_q;
	logic signed [31:0] xhi_q;
	logic signed [31:0] yhi_q;
	logic signed [31:0] shi_q;
	logic signed [32:0] h_q;
	logic               rneg_q;

	logic signed [63:0] a_q;
	logic signed [63:0] b_q;
	logic signed [63:0] q_q;
	logic signed [63:0] aa_q;
	logic signed [63:0] bb_q;
	logic signed [63:0] ta_q;
	logic signed [63:0] tb_q;
	logic signed [63:0] p_q;
	logic signed [63:0] t_q;
	logic signed [63:0] hh_q;
	logic signed [63:0] y_q;
	logic signed [63:0] dy_q;
	logic signed [63:0] ddy_q;

	logic [IW:0]   n_clamp;
	logic [IW-1:0] hi_init;
	logic [IW:0]   span;
	logic [IW-1:0] mid;
	logic [IW-1:0] lo_n;
	logic [IW-1:0] hi_n;
	logic [IW:0]   span_n;
	logic signed [32:0] h_new;

	logic signed [63:0] hq;
	logic signed [63:0] ylo64;
	logic signed [63:0] yhi64;
	logic signed [63:0] slo64;
	logic signed [63:0] shi64;
	logic signed [63:0] ta2;
	logic signed [63:0] tb2;
	logic signed [33:0] rn;
	logic [33:0]        rn_mag;
	logic [33:0]        h_mag;
	logic               is_div;
	logic               is_div6;
	logic signed [63:0] dq_val;
	logic signed [63:0] d6_val;

	csp_pkg::mul_req_t mreq;
	csp_pkg::mul_rsp_t mrsp;
	csp_pkg::div_req_t dreq;
	csp_pkg::div_rsp_t drsp;

	function automatic logic signed [63:0] times3(input logic signed [63:0] v);
		logic signed [63:0] r;
		r = csp_pkg::add_sat(csp_pkg::add_sat(v, v), v);
		return r;
	endfunction

	csp_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rsp    (mrsp)
	);

	csp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	assign pop     = (state_q == S_IDLE) && !empty;
	assign wr_en   = pop && !pop_data.is_query &&
		({26'd0, pop_data.index} < 32'(csp_pkg::MAX_KNOTS));
	assign wr_addr = IW'(pop_data.index);

	assign n_clamp = (knot_count < csp_pkg::CNT_W'(2)) ? (IW + 1)'(2) :
		((32'(knot_count) > csp_pkg::MAX_KNOTS) ? (IW + 1)'(csp_pkg::MAX_KNOTS) :
		(IW + 1)'(knot_count));
	assign hi_init = IW'(n_clamp - 1'b1);
	assign span    = {1'b0, hi_q} - {1'b0, lo_q};
	assign mid     = IW'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);
	assign lo_n    = ($signed(rd_x) > x_q) ? lo_q : mid;
	assign hi_n    = ($signed(rd_x) > x_q) ? mid : hi_q;
	assign span_n  = {1'b0, hi_n} - {1'b0, lo_n};
	assign h_new   = {rd_x[31], rd_x} - {xlo_q[31], xlo_q};

	always_comb begin
		case (state_q)
			S_LD_LO: rd_addr = lo_q;
			S_LD_HI: rd_addr = hi_q;
			default: rd_addr = mid;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_x[wr_addr] <= pop_data.xa;
			mem_y[wr_addr] <= pop_data.y;
			mem_s[wr_addr] <= pop_data.s;
		end
		rd_x <= mem_x[rd_addr];
		rd_y <= mem_y[rd_addr];
		rd_s <= mem_s[rd_addr];
	end

	assign hq    = {{23{h_q[32]}}, h_q, 8'd0};
	assign ylo64 = {{24{ylo_q[31]}}, ylo_q, 8'd0};
	assign yhi64 = {{24{yhi_q[31]}}, yhi_q, 8'd0};
	assign slo64 = {{24{slo_q[31]}}, slo_q, 8'd0};
	assign shi64 = {{24{shi_q[31]}}, shi_q, 8'd0};
	assign ta2   = csp_pkg::sub_sat(times3(aa_q), csp_pkg::Q_ONE);
	assign tb2   = csp_pkg::sub_sat(times3(bb_q), csp_pkg::Q_ONE);
	assign h_mag = h_q[32] ? 34'(-h_q) : 34'(h_q);
	assign rn_mag = rn[33] ? 34'(-rn) : 34'(rn);
	assign dq_val = csp_pkg::from_mag(drsp.quo, rneg_q);
	assign d6_val = csp_pkg::from_mag(mrsp.res, rneg_q);

	always_comb begin
		case (step_q)
			P_A:     rn = {{2{xhi_q[31]}}, xhi_q} - {{2{x_q[31]}}, x_q};
			P_B:     rn = {{2{x_q[31]}}, x_q} - {{2{xlo_q[31]}}, xlo_q};
			default: rn = {{2{yhi_q[31]}}, yhi_q} - {{2{ylo_q[31]}}, ylo_q};
		endcase
	end

	assign is_div6 = (step_q == P_DIV6Y) || (step_q == P_DIV6D);
	assign is_div  = (step_q == P_A) || (step_q == P_B) || (step_q == P_Q);

	always_comb begin
		dreq.start = (state_q == S_ISSUE) && is_div;
		dreq.num   = 64'({rn_mag, 24'd0}) + 64'(h_mag >> 1);
		dreq.den   = h_mag;
	end

	always_comb begin
		mreq.start = (state_q == S_ISSUE) && !is_div;
		mreq.raw   = is_div6;
		case (step_q)
			P_AA:    begin mreq.x = a_q;  mreq.y = a_q;   end
			P_AAA:   begin mreq.x = aa_q; mreq.y = a_q;   end
			P_BB:    begin mreq.x = b_q;  mreq.y = b_q;   end
			P_BBB:   begin mreq.x = bb_q; mreq.y = b_q;   end
			P_TSLO:  begin mreq.x = ta_q; mreq.y = slo64; end
			P_TSHI:  begin mreq.x = tb_q; mreq.y = shi64; end
			P_HH:    begin mreq.x = hq;   mreq.y = hq;    end
			P_THH:   begin mreq.x = t_q;  mreq.y = hh_q;  end
			P_AY:    begin mreq.x = a_q;  mreq.y = ylo64; end
			P_BY:    begin mreq.x = b_q;  mreq.y = yhi64; end
			P_DSLO:  begin mreq.x = ta2;  mreq.y = slo64; end
			P_DSHI:  begin mreq.x = tb2;  mreq.y = shi64; end
			P_TH:    begin mreq.x = t_q;  mreq.y = hq;    end
			P_CSLO:  begin mreq.x = a_q;  mreq.y = slo64; end
			P_CSHI:  begin mreq.x = b_q;  mreq.y = shi64; end
			P_DIV6Y, P_DIV6D: begin
				mreq.x = $signed(csp_pkg::mag(t_q) + 64'd3);
				mreq.y = $signed(csp_pkg::RECIP6);
			end
			default: begin mreq.x = a_q;  mreq.y = b_q;   end
		endcase
	end

	assign out_valid = res_valid_q;
	assign out_data  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= P_A;
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && out_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (pop && pop_data.is_query) begin
						state_q <= (hi_init > IW'(1)) ? S_SRCH_RD : S_LD_LO;
					end
				end
				S_SRCH_RD: state_q <= S_SRCH_CMP;
				S_SRCH_CMP: state_q <= (span_n > (IW + 1)'(1)) ? S_SRCH_RD : S_LD_LO;
				S_LD_LO: state_q <= S_LD_HI;
				S_LD_HI: state_q <= S_LD_END;
				S_LD_END: begin
					step_q  <= P_A;
					state_q <= (h_new == '0) ? S_STORE : S_ISSUE;
				end
				S_ISSUE: state_q <= S_WAIT;
				S_WAIT: begin
					if ((is_div && drsp.done) || (!is_div && mrsp.done)) begin
						if (step_q == P_CSHI) begin
							state_q <= S_STORE;
						end else begin
							step_q  <= step_q + 1'b1;
							state_q <= S_ISSUE;
						end
					end
				end
				S_STORE: begin
					if (!res_valid_q) begin
						res_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				x_q  <= pop_data.xa;
				lo_q <= '0;
				hi_q <= hi_init;
			end
			S_SRCH_CMP: begin
				lo_q <= lo_n;
				hi_q <= hi_n;
			end
			S_LD_HI: begin
				xlo_q <= rd_x;
				ylo_q <= rd_y;
				slo_q <= rd_s;
			end
			S_LD_END: begin
				xhi_q <= rd_x;
				yhi_q <= rd_y;
				shi_q <= rd_s;
				h_q   <= h_new;
				bad_q <= (h_new == '0);
			end
			S_ISSUE: begin
				rneg_q <= is_div6 ? t_q[63] : (rn[33] ^ h_q[32]);
			end
			S_WAIT: begin
				case (step_q)
					P_A:     a_q   <= dq_val;
					P_B:     b_q   <= dq_val;
					P_Q:     q_q   <= dq_val;
					P_AA:    aa_q  <= mrsp.res;
					P_AAA:   ta_q  <= csp_pkg::sub_sat(mrsp.res, a_q);
					P_BB:    bb_q  <= mrsp.res;
					P_BBB:   tb_q  <= csp_pkg::sub_sat(mrsp.res, b_q);
					P_TSLO:  p_q   <= mrsp.res;
					P_TSHI:  t_q   <= csp_pkg::add_sat(p_q, mrsp.res);
					P_HH:    hh_q  <= mrsp.res;
					P_THH:   t_q   <= mrsp.res;
					P_DIV6Y: t_q   <= d6_val;
					P_AY:    p_q   <= mrsp.res;
					P_BY:    y_q   <= csp_pkg::add_sat(csp_pkg::add_sat(p_q, mrsp.res), t_q);
					P_DSLO:  p_q   <= mrsp.res;
					P_DSHI:  t_q   <= csp_pkg::sub_sat(p_q, mrsp.res);
					P_TH:    t_q   <= mrsp.res;
					P_DIV6D: dy_q  <= csp_pkg::sub_sat(q_q, d6_val);
					P_CSLO:  p_q   <= mrsp.res;
					P_CSHI:  ddy_q <= csp_pkg::add_sat(p_q, mrsp.res);
					default: p_q   <= p_q;
				endcase
			end
			S_STORE: begin
				if (!res_valid_q) begin
					res_q.bad_knots <= bad_q;
					res_q.value     <= bad_q ? '0 : csp_pkg::to_out(y_q);
					res_q.slope     <= bad_q ? '0 : csp_pkg::to_out(dy_q);
					res_q.curvature <= bad_q ? '0 : csp_pkg::to_out(ddy_q);
				end
			end
			default: begin
			end
		endcase
	end

endmodule

### hdl/cubic_spline_evaluator_top.sv
// Top level of the cubic spline evaluator
//
//  channel | direction | handshake           | payload
//  in      | input     | in_valid/in_ready   | in_data  (csp_pkg::in_item_t)
//  out     | output    | out_valid/out_ready | out_data (csp_pkg::out_item_t)
//  cfg     | input     | cfg_we              | cfg_wdata (knot_count)
//
// A query on an interval of nonzero width runs up to six search probes, each a
// read state and a compare state, three divisions in the bit-serial divider and
// seventeen products in the shared 32x32 multiplier, two of them reciprocal
// multiplies for the divisions by six.
// arst_n clears control state and sets knot_count to 2; knot memories are not
// cleared. A four-beat queue decouples input acceptance from the engine, and
// the result register lets the engine start the next item while a result waits.
`timescale 1ns / 1ps
module cubic_spline_evaluator_top (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  csp_pkg::in_item_t         in_data,
	output logic                      out_valid,
	input  logic                      out_ready,
	output csp_pkg::out_item_t        out_data,
	input  logic                      cfg_we,
	input  logic [csp_pkg::CNT_W-1:0] cfg_wdata
);

	logic [csp_pkg::CNT_W-1:0] knot_count_q;
	logic            push;
	logic            full;
	logic            pop;
	logic            empty;
	csp_pkg::entry_t push_data;
	csp_pkg::entry_t pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			knot_count_q <= csp_pkg::CNT_W'(2);
		end else if (cfg_we) begin
			knot_count_q <= cfg_wdata;
		end
	end

	csp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	csp_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.empty     (empty),
		.pop_data  (pop_data)
	);

	csp_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.knot_count (knot_count_q),
		.empty      (empty),
		.pop_data   (pop_data),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule

### hdl/csp_checker.sv
// Port checker for the spline evaluator, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"
module csp_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input csp_pkg::in_item_t         in_data,
	input logic                      out_valid,
	input logic                      out_ready,
	input csp_pkg::out_item_t        out_data,
	input logic                      cfg_we,
	input logic [csp_pkg::CNT_W-1:0] cfg_wdata
);

	`CSP_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid)
	`CSP_ASSERT_HOLD(a_out_stable, out_valid, out_ready, out_data)
	`CSP_ASSERT(a_bad_zero, out_valid && out_data.bad_knots |-> out_data[96:1] == '0)
	`CSP_ASSERT(a_reset_quiet, $rose(arst_n) |-> !out_valid)

endmodule

bind cubic_spline_evaluator_top csp_checker u_chk (.*);

### tb/tb.sv
// Testbench of the cubic spline evaluator: knot loads, queries and a self-checking predictor
`timescale 1ns / 1ps
module tb;

	localparam int IDLE_LIMIT = 50000;
	localparam int SETTLE     = 600;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	csp_pkg::in_item_t  in_data = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	csp_pkg::out_item_t out_data;
	logic               cfg_we = 1'b0;
	logic [csp_pkg::CNT_W-1:0] cfg_wdata = '0;

	logic signed [63:0] knot_x [csp_pkg::MAX_KNOTS];
	logic signed [63:0] knot_y [csp_pkg::MAX_KNOTS];
	logic signed [63:0] knot_s [csp_pkg::MAX_KNOTS];
	int unsigned        model_count = 2;
	csp_pkg::out_item_t pending_results [$];
	int                 src_idle = 0;
	int                 snk_stall = 0;
	int                 fail_count = 0;
	int                 quiet_cycles = 0;

	always #5 clk = ~clk;

	cubic_spline_evaluator_top DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	function automatic logic [63:0] abs64(input logic signed [63:0] v);
		return v < 0 ? 64'd0 - 64'(v) : 64'(v);
	endfunction

	function automatic logic signed [63:0] signed_of(input logic [63:0] m, input logic neg);
		if (neg) begin
			return m >= 64'h8000_0000_0000_0000 ? csp_pkg::Q_MIN : -$signed(m);
		end
		return m[63] ? csp_pkg::Q_MAX : $signed(m);
	endfunction

	function automatic logic signed [63:0] q_add(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [64:0] s;
		s = 65'(a) + 65'(b);
		if (s > 65'(csp_pkg::Q_MAX)) begin
			return csp_pkg::Q_MAX;
		end
		if (s < 65'(csp_pkg::Q_MIN)) begin
			return csp_pkg::Q_MIN;
		end
		return s[63:0];
	endfunction

	function automatic logic signed [63:0] q_sub(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [64:0] d;
		d = 65'(a) - 65'(b);
		if (d > 65'(csp_pkg::Q_MAX)) begin
			return csp_pkg::Q_MAX;
		end
		if (d < 65'(csp_pkg::Q_MIN)) begin
			return csp_pkg::Q_MIN;
		end
		return d[63:0];
	endfunction

	function automatic logic signed [63:0] q_mul(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic [127:0] p;
		logic         neg;
		neg = (a < 0) != (b < 0);
		p = {64'd0, abs64(a)} * {64'd0, abs64(b)};
		p = p + (128'd1 << (csp_pkg::FRAC - 1));
		if (|p[127:88]) begin
			return neg ? csp_pkg::Q_MIN : csp_pkg::Q_MAX;
		end
		return signed_of(p[87:24], neg);
	endfunction

	function automatic logic signed [63:0] q_ratio(input logic signed [63:0] n,
		input logic signed [63:0] d);
		logic [63:0] un;
		logic [63:0] ud;
		un = abs64(n) << csp_pkg::FRAC;
		ud = abs64(d);
		return signed_of((un + ud / 2) / ud, (n < 0) != (d < 0));
	endfunction

	function automatic logic signed [63:0] q_div6(input logic signed [63:0] v);
		return signed_of((abs64(v) + 64'd3) / 64'd6, v < 0);
	endfunction

	function automatic logic signed [63:0] q_times3(input logic signed [63:0] v);
		return q_add(q_add(v, v), v);
	endfunction

	function automatic logic [31:0] q_to_q16(input logic signed [63:0] v);
		logic signed [63:0] r;
		r = signed_of((abs64(v) + 64'd128) >> 8, v < 0);
		if (r > 64'sd2147483647) begin
			r = 64'sd2147483647;
		end
		if (r < -64'sd2147483648) begin
			r = -64'sd2147483648;
		end
		return r[31:0];
	endfunction

	function automatic int unsigned knots_used();
		if (model_count < 2) begin
			return 2;
		end
		return model_count > csp_pkg::MAX_KNOTS ? csp_pkg::MAX_KNOTS : model_count;
	endfunction

	function automatic csp_pkg::out_item_t spline_at(input logic signed [31:0] qx);
		csp_pkg::out_item_t r;
		int unsigned        lo, hi, mid;
		logic signed [63:0] x, h, a, b, hq, ylo, yhi, slo, shi, t, ta, tb, yv, dy;
		x = qx;
		lo = 0;
		hi = knots_used() - 1;
		while (hi - lo > 1) begin
			mid = (hi + lo) >> 1;
			if (knot_x[mid] > x) begin
				hi = mid;
			end else begin
				lo = mid;
			end
		end
		r = '0;
		h = knot_x[hi] - knot_x[lo];
		if (h == 0) begin
			r.bad_knots = 1'b1;
			return r;
		end
		a = q_ratio(knot_x[hi] - x, h);
		b = q_ratio(x - knot_x[lo], h);
		hq = h * 256;
		ylo = knot_y[lo] * 256;
		yhi = knot_y[hi] * 256;
		slo = knot_s[lo] * 256;
		shi = knot_s[hi] * 256;
		ta = q_sub(q_mul(q_mul(a, a), a), a);
		tb = q_sub(q_mul(q_mul(b, b), b), b);
		t = q_add(q_mul(ta, slo), q_mul(tb, shi));
		t = q_div6(q_mul(t, q_mul(hq, hq)));
		yv = q_add(q_add(q_mul(a, ylo), q_mul(b, yhi)), t);
		ta = q_sub(q_times3(q_mul(a, a)), csp_pkg::Q_ONE);
		tb = q_sub(q_times3(q_mul(b, b)), csp_pkg::Q_ONE);
		t = q_sub(q_mul(ta, slo), q_mul(tb, shi));
		t = q_div6(q_mul(t, hq));
		dy = q_sub(q_ratio(knot_y[hi] - knot_y[lo], h), t);
		r.value = q_to_q16(yv);
		r.slope = q_to_q16(dy);
		r.curvature = q_to_q16(q_add(q_mul(a, slo), q_mul(b, shi)));
		return r;
	endfunction

	task automatic send_beat(input csp_pkg::in_item_t it);
		if ($urandom_range(99) < src_idle) begin
			in_valid <= 1'b0;
			do begin
				@(negedge clk);
			end while ($urandom_range(99) < src_idle);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do begin
			@(posedge clk);
		end while (!in_ready);
		if (it.operation == csp_pkg::OP_WRITE) begin
			knot_x[it.knot_index] = it.knot_abscissa;
			knot_y[it.knot_index] = it.knot_ordinate;
			knot_s[it.knot_index] = it.knot_second_derivative;
		end else begin
			pending_results.push_back(spline_at(it.query_x));
		end
		@(negedge clk);
	endtask

	task automatic write_knot(input int idx, input logic [31:0] kx, input logic [31:0] ky,
		input logic [31:0] ks);
		csp_pkg::in_item_t it;
		it = '0;
		it.operation = csp_pkg::OP_WRITE;
		it.knot_index = idx[5:0];
		it.knot_abscissa = kx;
		it.knot_ordinate = ky;
		it.knot_second_derivative = ks;
		it.query_x = $urandom;
		send_beat(it);
	endtask

	task automatic query(input logic [31:0] qx);
		csp_pkg::in_item_t it;
		it = '0;
		it.operation = csp_pkg::OP_QUERY;
		it.knot_index = $urandom;
		it.knot_abscissa = $urandom;
		it.knot_ordinate = $urandom;
		it.knot_second_derivative = $urandom;
		it.query_x = qx;
		send_beat(it);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic set_knot_count(input int unsigned cnt);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= cnt[csp_pkg::CNT_W-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		model_count = cnt;
	endtask

	function automatic logic [31:0] rand_value();
		case ($urandom_range(3))
			0: return $urandom_range(0, 1 << 20) - (1 << 19);
			1: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return $urandom;
		endcase
	endfunction

	task automatic load_table();
		logic signed [63:0] kx;
		int                 step_max;
		kx = 64'sd0 - 64'sd2147483648 + $urandom_range(0, 1 << 26);
		step_max = $urandom_range(2) == 0 ? 16 : (1 << 25);
		for (int i = 0; i < csp_pkg::MAX_KNOTS; i++) begin
			write_knot(i, kx[31:0], rand_value(), rand_value());
			kx = kx + ($urandom_range(49) == 0 ? 0 : $urandom_range(1, step_max));
		end
	endtask

	task automatic random_query();
		logic signed [63:0] lo, hi, qv;
		logic [63:0]        span;
		int                 r;
		lo = knot_x[0];
		hi = knot_x[knots_used() - 1];
		r = $urandom_range(99);
		if (r < 10) begin
			query(knot_x[$urandom_range(knots_used() - 1)][31:0]);
		end else if (r < 80 && hi > lo) begin
			span = 64'(hi - lo) + 64'd1;
			qv = lo + $signed({$urandom, $urandom} % span);
			query(qv[31:0]);
		end else begin
			query($urandom);
		end
	endtask

	task automatic test_reset_table();
		for (int i = 0; i < csp_pkg::MAX_KNOTS; i++) begin
			write_knot(i, (i - 32) * 65536, i * 4096, 32'(-i * 1024));
		end
		query(32'h8000_0000);
		query(32'h7FFF_FFFF);
		query(-32 * 65536 + 12345);
	endtask

	task automatic test_directed();
		set_knot_count(64);
		query(0);
		query(5 * 65536 + 32768);
		query(32'h7FFF_FFFF);
		query(32'h8000_0000);
		write_knot(0, 0, 32'h8000_0000, 32'h7FFF_FFFF);
		write_knot(1, 1, 32'h7FFF_FFFF, 32'h8000_0000);
		set_knot_count(2);
		query(32'h8000_0000);
		query(32'h7FFF_FFFF);
		query(0);
		write_knot(1, 0, 65536, 65536);
		query(12345);
		write_knot(63, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		write_knot(1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		write_knot(2, -65536, 100, 200);
		write_knot(3, -2 * 65536, 300, 400);
		set_knot_count(4);
		query(-32768);
		query(32'h8000_0000);
		set_knot_count(0);
		query(77);
		set_knot_count(127);
		query(32'h7FFF_FFF0);
		query(32'h8000_0000);
	endtask

	task automatic test_random_phase(input int src, input int snk, input int queries);
		int n;
		src_idle = src;
		snk_stall = snk;
		drain();
		load_table();
		for (int k = 0; k < 3; k++) begin
			case ($urandom_range(4))
				0: n = $urandom_range(1);
				1: n = csp_pkg::MAX_KNOTS;
				2: n = $urandom_range(65, 127);
				default: n = $urandom_range(2, csp_pkg::MAX_KNOTS);
			endcase
			set_knot_count(n);
			for (int q = 0; q < queries / 3; q++) begin
				if ($urandom_range(19) == 0) begin
					write_knot($urandom_range(63), $urandom, $urandom, $urandom);
				end else begin
					random_query();
				end
			end
		end
	endtask

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= snk_stall);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result with none expected: actual %h", $time, out_data);
				fail_count++;
			end else begin
				if (out_data !== pending_results[0]) begin
					$display("%0t: mismatch expected value %h slope %h curv %h bad %b",
						$time, pending_results[0].value, pending_results[0].slope,
						pending_results[0].curvature, pending_results[0].bad_knots);
					$display("%0t:          actual   value %h slope %h curv %h bad %b",
						$time, out_data.value, out_data.slope, out_data.curvature,
						out_data.bad_knots);
					fail_count++;
				end
				void'(pending_results.pop_front());
			end
		end
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_reset_table();
		test_directed();
		test_random_phase(0, 0, 250);
		test_random_phase(60, 0, 250);
		test_random_phase(0, 60, 250);
		test_random_phase(27, 27, 250);
		drain();
		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

### filelist.f
+incdir+hdl
hdl/csp_pkg.sv
hdl/csp_front.sv
hdl/csp_fifo.sv
hdl/csp_mul.sv
hdl/csp_div.sv
hdl/csp_engine.sv
hdl/cubic_spline_evaluator_top.sv
hdl/csp_checker.sv
tb/tb.sv
